FILE: design/dvth_pkg.sv
// Shared types, constants and helpers for the two-hop distance-vector update core.
// No dependencies; imported by the cost store and the top level.
package dvth_pkg;

   // table geometry
   localparam int MAX_ROUTERS = 16;
   localparam int IDX_W       = $clog2(MAX_ROUTERS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int MEM_DEPTH   = MAX_ROUTERS * MAX_ROUTERS;

   // cost and distance widths
   localparam int COST_W = 16;
   localparam int DIST_W = COST_W + 1;
   localparam int ENTRY_W = COST_W + 1;

   // item function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // router count cap, sized for the count register
   localparam logic [CNT_W-1:0] ROUTER_CAP = CNT_W'(MAX_ROUTERS);

   // one table entry as seen by the search logic
   typedef struct packed {
      logic              linked;
      logic [COST_W-1:0] cost;
   } cost_entry_type;

   // query sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // symmetric table: a pair is stored once, at {lower index, higher index}
   function automatic logic [ADDR_W-1:0] pair_addr(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b);
      logic [ADDR_W-1:0] addr;
      if (a < b) begin
         addr = {a, b};
      end else begin
         addr = {b, a};
      end
      return addr;
   endfunction

endpackage

FILE: design/dvth_cost_mem.sv
// Link-cost store: two identical copies of the pair table, one read port each.
// Per-entry valid bits make never-written pairs read as unlinked. Uses dvth_pkg.
module dvth_cost_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [dvth_pkg::ADDR_W-1:0]   wr_addr,
   input  logic                          wr_unlinked,
   input  logic [dvth_pkg::COST_W-1:0]   wr_cost,
   input  logic [dvth_pkg::ADDR_W-1:0]   rd_addr_a,
   input  logic [dvth_pkg::ADDR_W-1:0]   rd_addr_b,
   output dvth_pkg::cost_entry_type      rd_a,
   output dvth_pkg::cost_entry_type      rd_b
);
   import dvth_pkg::*;

   logic [ENTRY_W-1:0] bank_a_ff [MEM_DEPTH];
   logic [ENTRY_W-1:0] bank_b_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff;
   logic [ENTRY_W-1:0] rdata_a_ff;
   logic [ENTRY_W-1:0] rdata_b_ff;
   logic               rvld_a_ff;
   logic               rvld_b_ff;
   logic [ENTRY_W-1:0] wr_word;

   assign wr_word = {wr_unlinked, wr_cost};

   // both copies take every write, reads are registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_a_ff[wr_addr] <= wr_word;
         bank_b_ff[wr_addr] <= wr_word;
      end
      rdata_a_ff <= bank_a_ff[rd_addr_a];
      rdata_b_ff <= bank_b_ff[rd_addr_b];
      rvld_a_ff  <= valid_ff[rd_addr_a];
      rvld_b_ff  <= valid_ff[rd_addr_b];
   end

   // written flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // unwritten or marked entries read as unlinked
   assign rd_a.linked = rvld_a_ff & ~rdata_a_ff[ENTRY_W-1];
   assign rd_a.cost   = rdata_a_ff[COST_W-1:0];
   assign rd_b.linked = rvld_b_ff & ~rdata_b_ff[ENTRY_W-1];
   assign rd_b.cost   = rdata_b_ff[COST_W-1:0];

endmodule

FILE: design/distance_vector_two_hop_update_core.sv
// Two-hop distance-vector route query over a symmetric link-cost table of 16 routers.
// A write item updates both directions of a pair in a single table entry and gives no result. A query item
// reads the direct link, then one intermediate router per cycle from 0 to router_count-1 (router_count
// capped at the table size) through the two read ports of the cost store. The result goes into the
// output register once the scan drains and any waiting result is taken; the next item can be taken
// after that load, even while the result still waits in the output register. The table starts
// all unlinked right out of reset: per-entry valid bits stand in for a clearing pass.
// Depends on dvth_pkg and dvth_cost_mem.
module distance_vector_two_hop_update_core (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_write_en,
   input  logic [4:0]                    csr_write_data,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [3:0]                    req_source_router,
   input  logic [3:0]                    req_dest_router,
   input  logic [15:0]                   req_link_cost,
   input  logic                          req_no_link,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [16:0]                   rsp_distance,
   output logic                          rsp_reachable,
   output logic [3:0]                    rsp_next_hop
);
   import dvth_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   router_count_ff;
   logic [IDX_W-1:0]   src_ff, dst_ff;
   logic [CNT_W-1:0]   lim_ff;
   logic [CNT_W-1:0]   step_ff;
   logic               pend_ff;
   logic               pend_direct_ff;
   logic [IDX_W-1:0]   pend_k_ff;
   logic               diag_a_ff, diag_b_ff;
   logic               have_ff, have_in;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]   hop_ff, hop_in;
   logic               rsp_valid_ff;
   logic [DIST_W-1:0]  rsp_distance_ff;
   logic               rsp_reachable_ff;
   logic [IDX_W-1:0]   rsp_next_hop_ff;

   logic               req_take;
   logic               issue;
   logic               issue_last;
   logic               load_rsp;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   cur_k;
   logic [CNT_W-1:0]   step_m1;
   logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
   cost_entry_type     rd_a, rd_b;
   logic               link_a, link_b;
   logic [COST_W-1:0]  cost_a, cost_b;
   logic [DIST_W-1:0]  cand;

   assign req_take   = req_valid & req_ready;
   assign issue_last = (step_ff == lim_ff);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      issue     = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_func == FUNC_QUERY) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            issue = 1'b1;
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // router count register; the cap at the table size is applied when a query is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         router_count_ff <= ROUTER_CAP;
      end else if (csr_write_en) begin
         router_count_ff <= csr_write_data;
      end
   end

   // query context and step counter
   always_ff @(posedge clock) begin
      if (req_take) begin
         src_ff  <= req_source_router;
         dst_ff  <= req_dest_router;
         lim_ff  <= (router_count_ff > ROUTER_CAP) ? ROUTER_CAP : router_count_ff;
         step_ff <= '0;
      end else if (issue) begin
         step_ff <= step_ff + CNT_W'(1);
      end
   end

   // read addresses: step 0 is the direct pair, step n is intermediate n-1
   assign step_m1 = step_ff - CNT_W'(1);
   assign cur_k   = step_m1[IDX_W-1:0];
   assign rd_addr_a = (step_ff == '0) ? pair_addr(src_ff, dst_ff) : pair_addr(src_ff, cur_k);
   assign rd_addr_b = pair_addr(cur_k, dst_ff);

   assign mem_wr_en = req_take && (req_func == FUNC_WRITE) &&
                      (req_source_router != req_dest_router);

   dvth_cost_mem u_cost_mem (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (mem_wr_en),
      .wr_addr     (pair_addr(req_source_router, req_dest_router)),
      .wr_unlinked (req_no_link),
      .wr_cost     (req_link_cost),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .rd_a        (rd_a),
      .rd_b        (rd_b)
   );

   // read tags are registered alongside the registered memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      pend_direct_ff <= (step_ff == '0);
      pend_k_ff      <= cur_k;
      diag_a_ff      <= (step_ff == '0) ? (src_ff == dst_ff) : (src_ff == cur_k);
      diag_b_ff      <= (cur_k == dst_ff);
   end

   // diagonal always linked at zero cost
   assign link_a = diag_a_ff | rd_a.linked;
   assign link_b = diag_b_ff | rd_b.linked;
   assign cost_a = diag_a_ff ? '0 : rd_a.cost;
   assign cost_b = diag_b_ff ? '0 : rd_b.cost;
   assign cand   = DIST_W'(cost_a) + DIST_W'(cost_b);

   // running best: direct link first, then strictly better candidates
   always_comb begin
      have_in = have_ff;
      best_in = best_ff;
      hop_in  = hop_ff;
      if (pend_ff) begin
         if (pend_direct_ff) begin
            have_in = link_a;
            best_in = DIST_W'(cost_a);
            hop_in  = src_ff;
         end else if (link_a && link_b && (!have_ff || best_ff > cand)) begin
            have_in = 1'b1;
            best_in = cand;
            hop_in  = pend_k_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      have_ff <= have_in;
      best_ff <= best_in;
      hop_ff  <= hop_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_distance_ff  <= have_ff ? best_ff : '0;
         rsp_reachable_ff <= have_ff;
         rsp_next_hop_ff  <= have_ff ? hop_ff : src_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_reachable = rsp_reachable_ff;
   assign rsp_next_hop  = rsp_next_hop_ff;

`ifndef SYNTHESIS
   // no read result is outstanding while the sequencer sits idle or done
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !pend_ff)
      else $error("read result outstanding outside a scan");

   // the step counter never runs past the intermediate limit
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (step_ff <= lim_ff))
      else $error("scan step beyond limit");

   // a waiting result is never overwritten
   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result loaded over a waiting item");

   // the table is only written while the sequencer is idle
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_IDLE))
      else $error("table written during a query");
`endif

endmodule
